// ----- hw/rtl/i8sx_pkg.sv -----
// Shared types and constants for the IFF 8SVX stream parser.
// Depends on nothing; imported by i8sx_core and iff_8svx_stream_parser.
package i8sx_pkg;

  // Chunk and magic tags, big-endian ASCII.
  localparam logic [31:0] TagForm = 32'h464F_524D;
  localparam logic [31:0] Tag8svx = 32'h3853_5658;
  localparam logic [31:0] TagVhdr = 32'h5648_4452;
  localparam logic [31:0] TagBody = 32'h424F_4459;

  // Minimum VHDR payload size and last position of the file header.
  localparam logic [31:0] VhdrMinLen  = 32'd20;
  localparam logic [4:0]  VhdrEndOff  = 5'd20;
  localparam logic [3:0]  FileHdrLast = 4'd11;
  localparam logic [3:0]  FormLastPos = 4'd3;
  localparam logic [3:0]  ChunkTagEnd = 4'd4;
  localparam logic [3:0]  ChunkHdrLast = 4'd7;

  // Status codes reported with the final byte.
  localparam logic [3:0] StatOk         = 4'd0;
  localparam logic [3:0] StatTooShort   = 4'd1;
  localparam logic [3:0] StatBadMagic   = 4'd2;
  localparam logic [3:0] StatBadChunk   = 4'd3;
  localparam logic [3:0] StatNoVhdr     = 4'd4;
  localparam logic [3:0] StatNoBody     = 4'd5;
  localparam logic [3:0] StatZeroRate   = 4'd6;
  localparam logic [3:0] StatEmptyBody  = 4'd7;
  localparam logic [3:0] StatCompressed = 4'd8;

  // One input word: a file byte and its end mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic        sample_valid;
    logic [7:0]  sample_byte;
    logic        done_res;
    logic [3:0]  status;
    logic [15:0] rate_hz;
    logic [7:0]  octaves;
    logic [31:0] gain_word;
    logic [31:0] body_length;
  } out_word_t;

endpackage

// ----- hw/rtl/i8sx_core.sv -----
// Parser state machine: walks the file header and chunk headers, one byte per word.
// Depends on i8sx_pkg; instantiated by iff_8svx_stream_parser.
module i8sx_core import i8sx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  in_word_t  word_i,
  output out_word_t res_o
);

  typedef enum logic [2:0] {
    PhFile,
    PhChunk,
    PhPayload,
    PhPad,
    PhError
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic [4:0]  voff_q, voff_d;
  logic        seen_vhdr_q, seen_vhdr_d;
  logic        seen_body_q, seen_body_d;
  logic [15:0] rate_q, rate_d;
  logic [7:0]  oct_q, oct_d;
  logic [7:0]  pack_q, pack_d;
  logic [31:0] gain_q, gain_d;
  logic [31:0] blen_q, blen_d;
  logic [3:0]  err_q, err_d;

  logic [7:0]  b;
  logic        sv;
  logic [3:0]  status;

  assign b = word_i.data_byte;

  // Next state for one byte.
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    tag_d       = tag_q;
    len_d       = len_q;
    left_d      = left_q;
    voff_d      = voff_q;
    seen_vhdr_d = seen_vhdr_q;
    seen_body_d = seen_body_q;
    rate_d      = rate_q;
    oct_d       = oct_q;
    pack_d      = pack_q;
    gain_d      = gain_q;
    blen_d      = blen_q;
    err_d       = err_q;
    sv          = 1'b0;
    case (phase_q)
      PhFile: begin
        tag_d = {tag_q[23:0], b};
        if (pos_q == FormLastPos && tag_d != TagForm) begin
          err_d = StatBadMagic;
        end
        if (pos_q >= FileHdrLast) begin
          if (tag_d != Tag8svx) begin
            err_d = StatBadMagic;
          end
          pos_d   = '0;
          tag_d   = '0;
          phase_d = (err_d != StatOk) ? PhError : PhChunk;
        end else begin
          pos_d = pos_q + 4'd1;
        end
      end
      PhChunk: begin
        if (pos_q < ChunkTagEnd) begin
          tag_d = {tag_q[23:0], b};
        end else begin
          len_d = {len_q[23:0], b};
        end
        if (pos_q >= ChunkHdrLast) begin
          pos_d = '0;
          // Header complete: a short VHDR stops the parse.
          if (tag_d == TagVhdr && len_d < VhdrMinLen) begin
            err_d   = StatBadChunk;
            phase_d = PhError;
          end else begin
            if (tag_d == TagVhdr) begin
              seen_vhdr_d = 1'b1;
            end else if (tag_d == TagBody) begin
              seen_body_d = 1'b1;
              blen_d      = len_d;
            end
            left_d  = len_d;
            voff_d  = '0;
            phase_d = (len_d != '0) ? PhPayload : PhChunk;
          end
        end else begin
          pos_d = pos_q + 4'd1;
        end
      end
      PhPayload: begin
        if (tag_q == TagBody) begin
          sv = 1'b1;
        end else if (tag_q == TagVhdr) begin
          // Pick the VHDR fields out by their payload offset.
          case (voff_q)
            5'd12, 5'd13:               rate_d = {rate_q[7:0], b};
            5'd14:                      oct_d  = b;
            5'd15:                      pack_d = b;
            5'd16, 5'd17, 5'd18, 5'd19: gain_d = {gain_q[23:0], b};
            default: ;
          endcase
          if (voff_q < VhdrEndOff) begin
            voff_d = voff_q + 5'd1;
          end
        end
        left_d = left_q - 32'd1;
        if (left_d == '0) begin
          phase_d = len_q[0] ? PhPad : PhChunk;
        end
      end
      PhPad: begin
        phase_d = PhChunk;
      end
      default: ;
    endcase
  end

  // Final status from the state after this byte.
  always_comb begin
    if (phase_d == PhFile) begin
      status = StatTooShort;
    end else if (phase_d == PhError) begin
      status = err_d;
    end else if (phase_d == PhPayload && left_d != '0) begin
      status = StatBadChunk;
    end else if (!seen_vhdr_d) begin
      status = StatNoVhdr;
    end else if (!seen_body_d) begin
      status = StatNoBody;
    end else if (rate_d == '0) begin
      status = StatZeroRate;
    end else if (blen_d == '0) begin
      status = StatEmptyBody;
    end else if (pack_d != '0) begin
      status = StatCompressed;
    end else begin
      status = StatOk;
    end
  end

  // Result word; header fields appear only with the final byte.
  always_comb begin
    res_o              = '0;
    res_o.sample_valid = sv;
    res_o.sample_byte  = sv ? b : 8'd0;
    if (word_i.end_of_file) begin
      res_o.done_res    = 1'b1;
      res_o.status      = status;
      res_o.rate_hz     = rate_d;
      res_o.octaves     = oct_d;
      res_o.gain_word   = gain_d;
      res_o.body_length = blen_d;
    end
  end

  // State registers; the final byte rearms the parser.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhFile;
      pos_q       <= '0;
      tag_q       <= '0;
      len_q       <= '0;
      left_q      <= '0;
      voff_q      <= '0;
      seen_vhdr_q <= 1'b0;
      seen_body_q <= 1'b0;
      rate_q      <= '0;
      oct_q       <= '0;
      pack_q      <= '0;
      gain_q      <= '0;
      blen_q      <= '0;
      err_q       <= '0;
    end else if (take_i) begin
      if (word_i.end_of_file) begin
        phase_q     <= PhFile;
        pos_q       <= '0;
        tag_q       <= '0;
        len_q       <= '0;
        left_q      <= '0;
        voff_q      <= '0;
        seen_vhdr_q <= 1'b0;
        seen_body_q <= 1'b0;
        rate_q      <= '0;
        oct_q       <= '0;
        pack_q      <= '0;
        gain_q      <= '0;
        blen_q      <= '0;
        err_q       <= '0;
      end else begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        tag_q       <= tag_d;
        len_q       <= len_d;
        left_q      <= left_d;
        voff_q      <= voff_d;
        seen_vhdr_q <= seen_vhdr_d;
        seen_body_q <= seen_body_d;
        rate_q      <= rate_d;
        oct_q       <= oct_d;
        pack_q      <= pack_d;
        gain_q      <= gain_d;
        blen_q      <= blen_d;
        err_q       <= err_d;
      end
    end
  end

endmodule

// ----- hw/rtl/iff_8svx_stream_parser.sv -----
// Top level of the IFF 8SVX stream parser: parser core plus output register and skid stage.
// Depends on i8sx_pkg and i8sx_core.
//
//   channel | direction | handshake                | word
//   --------+-----------+--------------------------+-----------
//   input   | in        | in_valid_i / in_stall_o  | in_word_t
//   output  | out       | out_valid_o / out_stall_i| out_word_t
//
// One result word per input word; a byte is accepted every cycle while the skid stage is
// empty, and its result is registered in the output register, or in the skid stage if it stalls.
// The rate is set by the single parser state update per byte.
// Reset returns the parser to the file header phase and empties both buffers.
// A stalled output holds its word; one more result lands in the skid stage,
// and the input stalls only while that stage is full.
module iff_8svx_stream_parser import i8sx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  out_word_t res;
  out_word_t out_q, out_d;
  out_word_t skid_q, skid_d;
  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  logic      take;
  logic      out_free;

  assign in_stall_o = skid_valid_q;
  assign take       = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  i8sx_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .word_i (in_word_i),
    .res_o  (res)
  );

  // Output register and skid stage steering.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (take) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (take) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the IFF 8SVX stream parser: byte streams in, checked results out.
// Depends on i8sx_pkg and iff_8svx_stream_parser; a scoreboard class predicts every result word.
`timescale 1ns / 100ps

module testbench;
  import i8sx_pkg::*;

  // Parse phases of the predictor.
  typedef enum logic [2:0] {
    PhFile,
    PhChunk,
    PhPayload,
    PhPad,
    PhError
  } parse_phase_e;

  // Predicts the parser result for every accepted input word and checks the output words.
  class parse_scoreboard;
    parse_phase_e phase;
    logic [3:0]   hdr_pos;
    logic [31:0]  tag;
    logic [31:0]  chunk_len;
    logic [31:0]  left;
    logic [4:0]   vhdr_off;
    logic [1:0]   seen;
    logic [15:0]  rate;
    logic [7:0]   octaves;
    logic [7:0]   packing;
    logic [31:0]  gain;
    logic [31:0]  body_len;
    logic [3:0]   err;
    out_word_t    expected_q[$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase    = PhFile;
      hdr_pos  = '0;
      tag      = '0;
      chunk_len = '0;
      left     = '0;
      vhdr_off = '0;
      seen     = '0;
      rate     = '0;
      octaves  = '0;
      packing  = '0;
      gain     = '0;
      body_len = '0;
      err      = StatOk;
    endfunction

    // A complete chunk header decides what the payload means.
    function void open_chunk();
      if (tag == TagVhdr) begin
        if (chunk_len < VhdrMinLen) begin
          err   = StatBadChunk;
          phase = PhError;
          return;
        end
        seen[0] = 1'b1;
      end else if (tag == TagBody) begin
        seen[1]  = 1'b1;
        body_len = chunk_len;
      end
      left     = chunk_len;
      vhdr_off = '0;
      phase    = (chunk_len != 0) ? PhPayload : PhChunk;
    endfunction

    function logic [3:0] final_status();
      if (phase == PhFile) return StatTooShort;
      if (phase == PhError) return err;
      if (phase == PhPayload && left != 0) return StatBadChunk;
      if (!seen[0]) return StatNoVhdr;
      if (!seen[1]) return StatNoBody;
      if (rate == 0) return StatZeroRate;
      if (body_len == 0) return StatEmptyBody;
      if (packing != 0) return StatCompressed;
      return StatOk;
    endfunction

    // Advances the parse by one accepted word and queues its result word.
    function void note_word(in_word_t w);
      out_word_t  r;
      logic [7:0] b;
      r = '0;
      b = w.data_byte;
      case (phase)
        PhFile: begin
          tag = {tag[23:0], b};
          if (hdr_pos == FormLastPos && tag != TagForm) err = StatBadMagic;
          if (hdr_pos >= FileHdrLast) begin
            if (tag != Tag8svx) err = StatBadMagic;
            hdr_pos = '0;
            tag     = '0;
            phase   = (err != StatOk) ? PhError : PhChunk;
          end else begin
            hdr_pos = hdr_pos + 1'b1;
          end
        end
        PhChunk: begin
          if (hdr_pos < ChunkTagEnd) tag = {tag[23:0], b};
          else chunk_len = {chunk_len[23:0], b};
          if (hdr_pos >= ChunkHdrLast) begin
            hdr_pos = '0;
            open_chunk();
          end else begin
            hdr_pos = hdr_pos + 1'b1;
          end
        end
        PhPayload: begin
          if (tag == TagBody) begin
            r.sample_valid = 1'b1;
            r.sample_byte  = b;
          end else if (tag == TagVhdr) begin
            case (vhdr_off)
              5'd12, 5'd13: rate = {rate[7:0], b};
              5'd14: octaves = b;
              5'd15: packing = b;
              5'd16, 5'd17, 5'd18, 5'd19: gain = {gain[23:0], b};
              default: ;
            endcase
            if (vhdr_off < VhdrEndOff) vhdr_off = vhdr_off + 1'b1;
          end
          left = left - 1;
          if (left == 0) phase = chunk_len[0] ? PhPad : PhChunk;
        end
        PhPad: phase = PhChunk;
        default: ;
      endcase
      if (w.end_of_file) begin
        r.done_res    = 1'b1;
        r.status      = final_status();
        r.rate_hz     = rate;
        r.octaves     = octaves;
        r.gain_word   = gain;
        r.body_length = body_len;
        clear_state();
      end
      expected_q.push_back(r);
    endfunction

    // Compares one output word with the oldest expected word.
    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word %h", got);
        return;
      end
      exp_w = expected_q.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected sv=%0d sb=%h done=%0d st=%0d rate=%0d oct=%0d ",
                    "gain=%h len=%h, got sv=%0d sb=%h done=%0d st=%0d rate=%0d oct=%0d ",
                    "gain=%h len=%h"},
                   exp_w.sample_valid, exp_w.sample_byte, exp_w.done_res, exp_w.status,
                   exp_w.rate_hz, exp_w.octaves, exp_w.gain_word, exp_w.body_length,
                   got.sample_valid, got.sample_byte, got.done_res, got.status,
                   got.rate_hz, got.octaves, got.gain_word, got.body_length);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  parse_scoreboard sb = new();
  logic [7:0]  file_bytes[$];
  int unsigned words_sent = 0;
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 47;

  iff_8svx_stream_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #6 clk_i = ~clk_i;

  // Note every accepted input word.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) sb.note_word(in_word);
  end

  // Check every accepted result word and stall the output at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_word(out_word);
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic void push_be32(logic [31:0] v);
    file_bytes.push_back(v[31:24]);
    file_bytes.push_back(v[23:16]);
    file_bytes.push_back(v[15:8]);
    file_bytes.push_back(v[7:0]);
  endfunction

  // Builds one file: mostly well-formed chunk sequences, some noise, corruption and truncation.
  function automatic void build_random_file();
    int unsigned kind, nchunks, sel, cut;
    logic [31:0] tag, len;
    logic [15:0] rate;
    logic [7:0]  packing;
    bit          ended;
    file_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom));
      return;
    end
    push_be32(TagForm);
    push_be32($urandom);
    push_be32(Tag8svx);
    if (kind < 14) begin
      sel = $urandom_range(0, 11);
      file_bytes[sel] = file_bytes[sel] ^ (8'd1 << $urandom_range(0, 7));
    end
    nchunks = $urandom_range(1, 4);
    ended = 1'b0;
    for (int k = 0; k < nchunks && !ended; k++) begin
      sel = $urandom_range(0, 99);
      if ((k == 0 && sel < 85) || (k > 0 && sel < 20)) tag = TagVhdr;
      else if (sel < 75) tag = TagBody;
      else tag = $urandom;
      sel = $urandom_range(0, 99);
      if (tag == TagVhdr) begin
        len = (sel < 8) ? $urandom_range(0, 19) : (sel < 85) ? 32'd20 : $urandom_range(21, 25);
      end else if (tag == TagBody) begin
        len = (sel < 8) ? 32'd0 : (sel < 12) ? ($urandom | 32'h100) : $urandom_range(1, 12);
      end else begin
        len = (sel < 5) ? ($urandom | 32'h100) : $urandom_range(0, 7);
      end
      push_be32(tag);
      push_be32(len);
      // A declared size far beyond the file ends it inside the payload.
      if (len > 64) begin
        repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
        ended = 1'b1;
      end else begin
        rate    = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
        packing = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
        for (int i = 0; i < len; i++) begin
          if (tag == TagVhdr && i == 12) file_bytes.push_back(rate[15:8]);
          else if (tag == TagVhdr && i == 13) file_bytes.push_back(rate[7:0]);
          else if (tag == TagVhdr && i == 15) file_bytes.push_back(packing);
          else file_bytes.push_back(8'($urandom));
        end
        // The pad byte may go missing only at the very end.
        if (len[0] && (k != nchunks - 1 || $urandom_range(0, 9) >= 3))
          file_bytes.push_back(8'($urandom));
      end
    end
    if ($urandom_range(0, 99) < 12) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endfunction

  // Offers one word, with random idle cycles before it, and waits until it is taken.
  task automatic send_word(logic [7:0] b, logic eof);
    in_word_t w;
    w.data_byte   = b;
    w.end_of_file = eof;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_word(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
  endtask

  // Holds the input idle until every expected word has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a one-byte file, a short file with a bad magic, a bare header.
    file_bytes.push_back(8'h00);
    send_file();
    push_be32(32'h464F_5258);
    push_be32(32'h0000_0000);
    file_bytes.push_back(8'h38);
    file_bytes.push_back(8'h53);
    file_bytes.push_back(8'h56);
    send_file();
    push_be32(TagForm);
    push_be32(32'hFFFF_FFFF);
    push_be32(Tag8svx);
    send_file();

    // Random files, in three idling phases.
    while (words_sent < 1150) begin
      if (words_sent >= 400 && send_idle_pct == 17) begin
        wait_for_results();
        send_idle_pct = 47;
        recv_idle_pct = 17;
      end else if (words_sent >= 800 && send_idle_pct == 47) begin
        wait_for_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      build_random_file();
      send_file();
    end

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/i8sx_pkg.sv
hw/rtl/i8sx_core.sv
hw/rtl/iff_8svx_stream_parser.sv
sim/testbench.sv
